### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl files
// clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### hdl/vctp_pkg.sv
// ---------------------------------------------------------------------------
// vctp_pkg
// types, constants and color conversion for the color table port
// ---------------------------------------------------------------------------
`default_nettype none

package vctp_pkg;

  localparam int unsigned COLOR_ENTRIES = 512;
  localparam int unsigned ENTRY_AW      = $clog2(COLOR_ENTRIES);
  localparam int unsigned ENTRY_W       = 9;
  localparam int unsigned BUS_AW        = 11;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned PIX_IDX_W     = 9;
  localparam int unsigned PIX_COL_W     = 16;
  localparam int unsigned BURST_CW      = 4;

  // register map (word addresses, bit 0 selects low or high byte)
  localparam logic [BUS_AW-1:0] REG_CTRL  = 11'h400;
  localparam logic [BUS_AW-1:0] REG_TADDR = 11'h402;
  localparam logic [BUS_AW-1:0] REG_TDATA = 11'h404;

  localparam logic [DATA_W-1:0]   UNMAPPED_READ = 8'hFF;
  localparam logic [BURST_CW-1:0] BURST_LAST    = 4'hF;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_BURST
  } vctp_state_e;

  // 9-bit color (blue 0-2, red 3-5, green 6-8) to 16-bit cache format
  function automatic logic [PIX_COL_W-1:0] to_rgb(input logic [ENTRY_W-1:0] c);
    return {c[5:3], 2'b00, c[8:6], 3'b000, c[2:0], 2'b00};
  endfunction

endpackage

`default_nettype wire

### hdl/vctp_cmd_if.sv
// ---------------------------------------------------------------------------
// vctp_cmd_if
// bus access channel: valid/ready handshake with mode, address and data
// ---------------------------------------------------------------------------
`default_nettype none

interface vctp_cmd_if
  import vctp_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [BUS_AW-1:0]   address;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, mode, address, write_data, input ready);
  modport sink   (input valid, mode, address, write_data, output ready);
endinterface

`default_nettype wire

### hdl/vctp_res_if.sv
// ---------------------------------------------------------------------------
// vctp_res_if
// result channel: read data or pixel cache update, valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface vctp_res_if
  import vctp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 result_kind;
  logic [DATA_W-1:0]    read_data;
  logic [PIX_IDX_W-1:0] pixel_index;
  logic [PIX_COL_W-1:0] pixel_color;
  logic                 last;

  modport source (output valid, result_kind, read_data, pixel_index, pixel_color, last,
                  input ready);
  modport sink   (input valid, result_kind, read_data, pixel_index, pixel_color, last,
                  output ready);
endinterface

`default_nettype wire

### hdl/video_color_table_port_unit.sv
// ---------------------------------------------------------------------------
// video_color_table_port_unit
// palette controller: byte registers over a 512 x 9 color ram
// ---------------------------------------------------------------------------
// flow: an item is captured with its registered ram read, then ST_LOOKUP does
//   the read-modify-write and loads the output register once it is free; no
//   item is accepted until ST_IDLE again, nor during a sixteen-update write
// reset: control state clears at once, then a clearing pass zeroes
//   the color ram, one entry a cycle, and no item is accepted until it ends
`default_nettype none

`include "assert_macros.svh"

module video_color_table_port_unit
  import vctp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  vctp_cmd_if.sink        in_i,
  vctp_res_if.source      out_o
);

  // control state
  vctp_state_e          state_q, state_d;
  logic [ENTRY_AW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [BURST_CW-1:0]  burst_cnt_q, burst_cnt_d;
  logic [ENTRY_AW-1:0]  table_addr_q, table_addr_d;
  logic                 control_q, control_d;
  // copy of entry 0, used for the sixteen-update broadcast
  logic [ENTRY_W-1:0]   entry0_q, entry0_d;

  // captured item
  logic                 cmd_mode_q;
  logic [BUS_AW-1:0]    cmd_addr_q;
  logic [DATA_W-1:0]    cmd_data_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 out_kind_q, out_kind_d;
  logic [DATA_W-1:0]    out_rdata_q, out_rdata_d;
  logic [PIX_IDX_W-1:0] out_index_q, out_index_d;
  logic [PIX_COL_W-1:0] out_color_q, out_color_d;
  logic                 out_last_q, out_last_d;

  // color ram
  logic [ENTRY_W-1:0]   ram_q [COLOR_ENTRIES];
  logic [ENTRY_W-1:0]   ram_rdata_q;
  logic                 ram_we;
  logic [ENTRY_AW-1:0]  ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;

  logic                 in_fire;
  logic                 out_free;
  logic                 cmd_hi;
  logic                 hit_ctrl, hit_taddr, hit_tdata;
  logic [DATA_W-1:0]    stored_byte;
  logic [ENTRY_W-1:0]   new_entry;
  logic                 data_changed;
  logic [ENTRY_AW-1:0]  table_addr_inc;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  // output register can take a new result this cycle
  assign out_free   = !out_valid_q || out_o.ready;

  // register decode on the captured item, bit 0 picks the byte
  assign cmd_hi    = cmd_addr_q[0];
  assign hit_ctrl  = (cmd_addr_q[BUS_AW-1:1] == REG_CTRL[BUS_AW-1:1]);
  assign hit_taddr = (cmd_addr_q[BUS_AW-1:1] == REG_TADDR[BUS_AW-1:1]);
  assign hit_tdata = (cmd_addr_q[BUS_AW-1:1] == REG_TDATA[BUS_AW-1:1]);

  // selected byte of the addressed entry, and the entry after a data write
  assign stored_byte  = cmd_hi ? {{(DATA_W-1){1'b0}}, ram_rdata_q[ENTRY_W-1]}
                               : ram_rdata_q[DATA_W-1:0];
  assign new_entry    = cmd_hi ? {cmd_data_q[0], ram_rdata_q[DATA_W-1:0]}
                               : {ram_rdata_q[ENTRY_W-1], cmd_data_q};
  assign data_changed = (cmd_data_q != stored_byte);
  assign table_addr_inc = table_addr_q + ENTRY_AW'(1);

  // ram: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_q[ram_waddr] <= ram_wdata;
    end
    if (in_fire) begin
      ram_rdata_q <= ram_q[table_addr_q];
    end
  end

  // item capture, payload only
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_mode_q <= in_i.mode;
      cmd_addr_q <= in_i.address;
      cmd_data_q <= in_i.write_data;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_kind_q  <= out_kind_d;
    out_rdata_q <= out_rdata_d;
    out_index_q <= out_index_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      burst_cnt_q  <= '0;
      table_addr_q <= '0;
      control_q    <= 1'b0;
      entry0_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      burst_cnt_q  <= burst_cnt_d;
      table_addr_q <= table_addr_d;
      control_q    <= control_d;
      entry0_q     <= entry0_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    burst_cnt_d  = burst_cnt_q;
    table_addr_d = table_addr_q;
    control_d    = control_q;
    entry0_d     = entry0_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_kind_d   = out_kind_q;
    out_rdata_d  = out_rdata_q;
    out_index_d  = out_index_q;
    out_color_d  = out_color_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = table_addr_q;
    ram_wdata    = new_entry;

    unique case (state_q)
      ST_CLEAR: begin
        // zero one entry a cycle
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + ENTRY_AW'(1);
        if (clr_cnt_q == ENTRY_AW'(COLOR_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOOKUP;
        end
      end

      ST_LOOKUP: begin
        // ram data is here; act once the output register is free
        if (out_free) begin
          state_d = ST_IDLE;
          if (cmd_mode_q == MODE_READ) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_READ;
            out_rdata_d = hit_tdata ? stored_byte : UNMAPPED_READ;
            out_index_d = '0;
            out_color_d = '0;
            out_last_d  = 1'b1;
            if (hit_tdata && cmd_hi) begin
              table_addr_d = table_addr_inc;
            end
          end else begin
            if (hit_ctrl && !cmd_hi) begin
              control_d = cmd_data_q[0];
            end
            if (hit_taddr) begin
              if (cmd_hi) begin
                table_addr_d = {cmd_data_q[0], table_addr_q[DATA_W-1:0]};
              end else begin
                table_addr_d = {table_addr_q[ENTRY_AW-1], cmd_data_q};
              end
            end
            if (hit_tdata) begin
              if (data_changed) begin
                ram_we = 1'b1;
                if (table_addr_q == '0) begin
                  entry0_d = new_entry;
                end
                out_valid_d = 1'b1;
                out_kind_d  = KIND_PIXEL;
                out_rdata_d = '0;
                if (table_addr_q[3:0] != 4'h0) begin
                  // single update for this entry
                  out_index_d = PIX_IDX_W'(table_addr_q);
                  out_color_d = to_rgb(new_entry);
                  out_last_d  = 1'b1;
                end else begin
                  // color 0 broadcast to every sixteenth entry of bank 0
                  out_index_d = '0;
                  out_color_d = to_rgb((table_addr_q == '0) ? new_entry : entry0_q);
                  out_last_d  = 1'b0;
                  burst_cnt_d = BURST_CW'(1);
                  state_d     = ST_BURST;
                end
              end
              if (cmd_hi) begin
                table_addr_d = table_addr_inc;
              end
            end
          end
        end
      end

      ST_BURST: begin
        // output register holds an update here, step on each take
        if (out_o.ready) begin
          out_valid_d = 1'b1;
          out_index_d = {1'b0, burst_cnt_q, 4'h0};
          out_last_d  = (burst_cnt_q == BURST_LAST);
          burst_cnt_d = burst_cnt_q + BURST_CW'(1);
          if (burst_cnt_q == BURST_LAST) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.read_data   = out_rdata_q;
  assign out_o.pixel_index = out_index_q;
  assign out_o.pixel_color = out_color_q;
  assign out_o.last        = out_last_q;

  // no result can leave while the ram is being cleared
  `ASSERT_NEVER(a_no_out_in_clear, (state_q == ST_CLEAR) && out_valid_q,
                "result valid during clearing pass")
  // a read always gives exactly one result
  `ASSERT_CLK(a_read_is_last, (out_valid_q && (out_kind_q == KIND_READ)) |-> out_last_q,
              "read result without last")
  // the entry 0 copy tracks every ram write to entry 0
  `ASSERT_CLK(a_entry0_copy, (ram_we && (ram_waddr == '0)) |=> (entry0_q == $past(ram_wdata)),
              "entry 0 copy out of step with ram")
  // during a broadcast the output register never drains
  `ASSERT_CLK(a_burst_holds_out, (state_q == ST_BURST) |-> (out_valid_q && !out_last_q),
              "broadcast state without a pending update")

endmodule

`default_nettype wire

### tb/sv/vctp_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vctp_checker
// follows the bus channel, keeps its own color table and table address,
// and compares every returned result in order with the predicted one
// ---------------------------------------------------------------------------

module vctp_checker
  import vctp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  vctp_cmd_if         cmd_i,
  vctp_res_if         res_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic                 kind;
    logic [DATA_W-1:0]    read_data;
    logic [PIX_IDX_W-1:0] index;
    logic [PIX_COL_W-1:0] color;
    logic                 last;
  } port_result_t;

  port_result_t        awaited_q[$];
  port_result_t        seen;
  port_result_t        want;
  logic                ctrl_bit;
  logic [ENTRY_AW-1:0] table_addr;
  logic [ENTRY_W-1:0]  palette [COLOR_ENTRIES];
  int unsigned         mismatches;

  // 9-bit table color to the 16-bit cache layout
  function automatic logic [PIX_COL_W-1:0] cache_rgb(input logic [ENTRY_W-1:0] c);
    logic [PIX_COL_W-1:0] red;
    logic [PIX_COL_W-1:0] green;
    logic [PIX_COL_W-1:0] blue;
    red   = PIX_COL_W'(c[5:3]);
    green = PIX_COL_W'(c[8:6]);
    blue  = PIX_COL_W'(c[2:0]);
    return (red << 13) | (green << 8) | (blue << 2);
  endfunction

  function automatic port_result_t pixel_update(input logic [PIX_IDX_W-1:0] idx,
                                                input logic [PIX_COL_W-1:0] col,
                                                input logic fin);
    port_result_t r;
    r       = '0;
    r.kind  = KIND_PIXEL;
    r.index = idx;
    r.color = col;
    r.last  = fin;
    return r;
  endfunction

  task automatic predict_access(input logic mode, input logic [BUS_AW-1:0] addr,
                                input logic [DATA_W-1:0] data);
    logic                high;
    logic [BUS_AW-1:0]   reg_sel;
    logic [ENTRY_AW-1:0] ta;
    logic [ENTRY_W-1:0]  entry;
    logic [DATA_W-1:0]   stored;
    port_result_t        r;
    high    = addr[0];
    reg_sel = {addr[BUS_AW-1:1], 1'b0};
    ta      = table_addr;
    entry   = palette[ta];
    stored  = high ? DATA_W'(entry[ENTRY_W-1]) : entry[DATA_W-1:0];
    if (mode == MODE_READ) begin
      r           = '0;
      r.kind      = KIND_READ;
      r.read_data = (reg_sel == REG_TDATA) ? stored : UNMAPPED_READ;
      r.last      = 1'b1;
      awaited_q.push_back(r);
    end else if (reg_sel == REG_CTRL) begin
      if (!high) ctrl_bit = data[0];
    end else if (reg_sel == REG_TADDR) begin
      if (high) table_addr[ENTRY_AW-1] = data[0];
      else table_addr[DATA_W-1:0] = data;
    end else if (reg_sel == REG_TDATA && data != stored) begin
      // raw byte compare, so a high byte above 1 always counts as a change
      if (high) entry[ENTRY_W-1] = data[0];
      else entry[DATA_W-1:0] = data;
      palette[ta] = entry;
      if (ta[3:0] != '0) begin
        awaited_q.push_back(pixel_update(PIX_IDX_W'(ta), cache_rgb(entry), 1'b1));
      end else begin
        // overscan slot: color 0 fanned out to every sixteenth entry
        for (int n = 0; n < 16; n++) begin
          awaited_q.push_back(pixel_update(PIX_IDX_W'(n * 16), cache_rgb(palette[0]),
                                           n == 15));
        end
      end
    end
    // high data byte advances the address on reads and writes alike
    if (reg_sel == REG_TDATA && high) table_addr = ta + 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_q.delete();
      ctrl_bit   = 1'b0;
      table_addr = '0;
      for (int i = 0; i < COLOR_ENTRIES; i++) palette[i] = '0;
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        seen = {res_i.result_kind, res_i.read_data, res_i.pixel_index, res_i.pixel_color,
                res_i.last};
        if (awaited_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result kind=%0d data=%02h index=%03h color=%04h last=%0d",
                     $time, seen.kind, seen.read_data, seen.index, seen.color, seen.last);
        end else begin
          want = awaited_q.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected kind=%0d data=%02h index=%03h color=%04h last=%0d",
                       want.kind, want.read_data, want.index, want.color, want.last);
              $display("  actual   kind=%0d data=%02h index=%03h color=%04h last=%0d",
                       seen.kind, seen.read_data, seen.index, seen.color, seen.last);
            end
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        predict_access(cmd_i.mode, cmd_i.address, cmd_i.write_data);
      mismatch_count_o <= mismatches;
      pending_o        <= awaited_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// drives bus accesses into the color table port: a directed pass over the
// register map and the overscan fan-out, then random register sequences,
// with bursty offering on the bus and a stalling result receiver
// ---------------------------------------------------------------------------

module testbench;
  import vctp_pkg::*;

  // random items to accept, not counting writes the block ignores
  localparam int unsigned RANDOM_ITEMS  = 120;
  // long receiver hold-off, enough to back the block up to its input
  localparam int unsigned HOLD_CYCLES   = 400;
  // after the last result: a full sixteen-update burst plus margin
  localparam int unsigned SETTLE_CYCLES = 40;
  // reset and clearing pass, ~145 items x 16 results under heavy stall, x ~10
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // high byte addresses of the register pairs
  localparam logic [BUS_AW-1:0] CTRL_HI  = REG_CTRL | BUS_AW'(1);
  localparam logic [BUS_AW-1:0] TADDR_HI = REG_TADDR | BUS_AW'(1);
  localparam logic [BUS_AW-1:0] TDATA_HI = REG_TDATA | BUS_AW'(1);

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned items_done;
  logic        hold_req;
  int unsigned mismatch_count;
  int unsigned pending_count;

  vctp_cmd_if cmd_if ();
  vctp_res_if res_if ();

  video_color_table_port_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  vctp_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cmd_i            (cmd_if),
    .res_i            (res_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog, also covers the clearing pass after reset
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one bus access: offered in bursts, with a gap
  // whenever valid went low, so valid never drops and rises in one step
  task automatic bus_access(input logic mode, input logic [BUS_AW-1:0] addr,
                            input logic [DATA_W-1:0] data);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // mostly short bursts, now and then a long back-to-back stretch
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 6);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.mode       <= mode;
    cmd_if.address    <= addr;
    cmd_if.write_data <= data;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    burst_left--;
    if (burst_left == 0) cmd_if.valid <= 1'b0;
    // writes outside the control, address and data registers do nothing
    if (mode == MODE_READ || addr == REG_CTRL ||
        {addr[BUS_AW-1:1], 1'b0} == REG_TADDR || {addr[BUS_AW-1:1], 1'b0} == REG_TDATA)
      items_done++;
  endtask

  // sender pause: stop offering and wait for every predicted result
  task automatic drain_results();
    if (burst_left != 0) begin
      cmd_if.valid <= 1'b0;
      burst_left = 0;
    end
    // one edge first so the count includes the item just accepted
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // both address bytes; upper bits of the high byte are don't-care noise
  task automatic set_table_address(input logic [ENTRY_AW-1:0] target);
    logic [DATA_W-1:0] high_byte;
    high_byte    = DATA_W'($urandom());
    high_byte[0] = target[ENTRY_AW-1];
    bus_access(MODE_WRITE, REG_TADDR, target[DATA_W-1:0]);
    bus_access(MODE_WRITE, TADDR_HI, high_byte);
  endtask

  // result receiver: stall pattern changes from phase to phase, plus one
  // long hold-off on request while the sender keeps offering
  initial begin
    int unsigned phase_left;
    int unsigned stall_mode;
    logic        hold_done;
    res_if.ready <= 1'b0;
    phase_left = 0;
    stall_mode = 0;
    hold_done  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (phase_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      case (stall_mode)
        0:       res_if.ready <= 1'b1;                          // no stalls
        1:       res_if.ready <= 1'($urandom_range(0, 1));      // coin flip
        2:       res_if.ready <= ($urandom_range(0, 6) == 0);   // mostly stalled
        default: res_if.ready <= (phase_left % 4 != 0);         // periodic
      endcase
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned         runs;
    int unsigned         next_pause;
    logic [ENTRY_AW-1:0] target;
    logic [DATA_W-1:0]   low_byte;
    logic [DATA_W-1:0]   high_byte;
    cmd_if.valid      <= 1'b0;
    cmd_if.mode       <= MODE_READ;
    cmd_if.address    <= '0;
    cmd_if.write_data <= '0;
    burst_left = 0;
    items_done = 0;
    hold_req   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // freshly cleared table reads back zero, high byte read advances
    bus_access(MODE_READ, REG_TDATA, 8'h00);
    bus_access(MODE_READ, TDATA_HI, 8'hFF);
    // unmapped and write-only registers read as all ones
    bus_access(MODE_READ, 11'h7FF, 8'h00);
    bus_access(MODE_READ, REG_CTRL, 8'h00);
    // control write, ignored control high byte, ignored unmapped write
    bus_access(MODE_WRITE, REG_CTRL, 8'hFF);
    bus_access(MODE_WRITE, CTRL_HI, 8'h00);
    bus_access(MODE_WRITE, 11'h7FF, 8'hFF);
    // bank 1 overscan slot: fan-out carries color 0, not the entry written
    set_table_address(9'h100);
    bus_access(MODE_WRITE, REG_TDATA, 8'hFF);
    // same byte again: no change, nothing emitted
    bus_access(MODE_WRITE, REG_TDATA, 8'hFF);
    // high byte above 1 always counts as a change
    bus_access(MODE_WRITE, TDATA_HI, 8'h03);
    // ordinary entry: single update
    bus_access(MODE_WRITE, REG_TDATA, 8'hA5);
    // unchanged high byte still advances the address
    bus_access(MODE_WRITE, TDATA_HI, 8'h00);
    // last entry, then wrap back to zero on the high byte read
    set_table_address(9'h1FF);
    bus_access(MODE_WRITE, REG_TDATA, 8'h5A);
    bus_access(MODE_READ, REG_TDATA, 8'h00);
    bus_access(MODE_READ, TDATA_HI, 8'h00);
    // entry 0 itself: fan-out with the new color, both bytes
    bus_access(MODE_WRITE, REG_TDATA, 8'hFF);
    bus_access(MODE_WRITE, TDATA_HI, 8'h01);
    set_table_address(9'h000);
    bus_access(MODE_READ, REG_TDATA, 8'h00);
    bus_access(MODE_READ, TDATA_HI, 8'h00);
    drain_results();

    // ---- random part ----
    // receiver backs up early while the sender keeps going
    hold_req   = 1'b1;
    items_done = 0;
    next_pause = $urandom_range(20, 40);
    while (items_done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // new table address, often an overscan slot or near the wrap
          case ($urandom_range(0, 3))
            0:       target = ENTRY_AW'($urandom()) & 9'h1F0;
            1:       target = 9'h1F0 + ENTRY_AW'($urandom_range(0, 15));
            default: target = ENTRY_AW'($urandom());
          endcase
          set_table_address(target);
        end
        2, 3, 4, 5: begin
          // color writes, low then high byte, sometimes a repeated low byte
          runs = $urandom_range(1, 4);
          repeat (runs) begin
            low_byte = DATA_W'($urandom());
            bus_access(MODE_WRITE, REG_TDATA, low_byte);
            if ($urandom_range(0, 4) == 0) bus_access(MODE_WRITE, REG_TDATA, low_byte);
            high_byte = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom())
                                                     : DATA_W'($urandom_range(0, 1));
            bus_access(MODE_WRITE, TDATA_HI, high_byte);
          end
        end
        6, 7: begin
          // table read-back
          runs = $urandom_range(1, 4);
          repeat (runs) begin
            bus_access(MODE_READ, REG_TDATA, DATA_W'($urandom()));
            bus_access(MODE_READ, TDATA_HI, DATA_W'($urandom()));
          end
        end
        8: begin
          // noise: anywhere on the bus, or any byte of the register block
          bus_access(1'($urandom_range(0, 1)),
                     $urandom_range(0, 1) ? BUS_AW'($urandom())
                                          : REG_CTRL + BUS_AW'($urandom_range(0, 7)),
                     DATA_W'($urandom()));
        end
        default: bus_access(MODE_WRITE, REG_CTRL, DATA_W'($urandom()));
      endcase
      if (items_done >= next_pause) begin
        drain_results();
        next_pause = items_done + $urandom_range(20, 40);
      end
    end

    // wait out everything predicted, then a quiet stretch for strays
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
